// File: hdl/kium_pkg.sv
// shared constants, types and helpers for the k-way interval union merge
`default_nettype none

package kium_pkg;

  // sizes of the track store
  localparam int MAX_TRACKS = 4;
  localparam int EPT        = 16;
  localparam int TSEL_W     = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int IDX_W      = (EPT > 1) ? $clog2(EPT) : 1;
  localparam int CNT_W      = $clog2(EPT + 1);
  localparam int NEST_W     = $clog2(MAX_TRACKS + 1);

  // item field widths
  localparam int TRK_W = 2;
  localparam int POS_W = 31;
  localparam int ACT_W = 3;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic RIDX_ACTIVE = 1'b0;
  localparam logic [ACT_W-1:0] ACTIVE_RST = ACT_W'(MAX_TRACKS);

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // queued command
  typedef struct packed {
    logic             cmd;
    logic [TRK_W-1:0] track;
    logic [POS_W-1:0] position;
  } q_item_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // merge sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } bst_t;

  // clamp the track count register into 1..MAX_TRACKS
  function automatic logic [ACT_W-1:0] eff_tracks(input logic [ACT_W-1:0] raw);
    logic [ACT_W-1:0] res;
    if (raw == '0) begin
      res = ACT_W'(1);
    end else if (raw > ACT_W'(MAX_TRACKS)) begin
      res = ACT_W'(MAX_TRACKS);
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hdl/kium_if.sv
// item channel interfaces for input commands and merged results
`default_nettype none

interface kium_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [kium_pkg::TRK_W-1:0] track;
  logic [kium_pkg::POS_W-1:0] position;

  modport source (output valid, output cmd, output track, output position, input ready);
  modport sink   (input valid, input cmd, input track, input position, output ready);
endinterface

interface kium_out_if;
  logic                      valid;
  logic                      ready;
  logic [kium_pkg::POS_W-1:0] edge_res;
  logic                      is_begin;
  logic                      overflow;
  logic                      last;

  modport source (output valid, output edge_res, output is_begin, output overflow,
                  output last, input ready);
  modport sink   (input valid, input edge_res, input is_begin, input overflow,
                  input last, output ready);
endinterface

`default_nettype wire

// File: hdl/kium_front.sv
// front end: accepts input items and filters loads to inactive tracks
`default_nettype none

module kium_front (
  kium_in_if.sink                     in_chan,
  input  logic [kium_pkg::ACT_W-1:0]  act_eff,
  input  kium_pkg::q_stat_t           q_stat,
  output logic                        push,
  output kium_pkg::q_item_t           push_item
);
  import kium_pkg::*;

  logic keep;

  // take an item whenever the queue has room
  assign in_chan.ready = !q_stat.full;

  // end-of-read always passes, loads only for active tracks
  assign keep = (in_chan.cmd == CMD_END) ||
                ({{(ACT_W-TRK_W){1'b0}}, in_chan.track} < act_eff);

  assign push = in_chan.valid && in_chan.ready && keep;

  assign push_item.cmd      = in_chan.cmd;
  assign push_item.track    = in_chan.track;
  assign push_item.position = in_chan.position;

endmodule

`default_nettype wire

// File: hdl/kium_fifo.sv
// short command queue between front and back end
`default_nettype none

module kium_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  kium_pkg::q_item_t push_item,
  input  logic              pop,
  output kium_pkg::q_item_t pop_item,
  output kium_pkg::q_stat_t q_stat
);
  import kium_pkg::*;

  q_item_t           q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_item     = q_mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: hdl/kium_back.sv
// back end: track store, k-way merge sequencer and result register
`default_nettype none

module kium_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [kium_pkg::ACT_W-1:0]  act_eff,
  input  kium_pkg::q_item_t           pop_item,
  input  kium_pkg::q_stat_t           q_stat,
  output logic                        pop,
  kium_out_if.source                  out_chan
);
  import kium_pkg::*;

  // store banks, one per track, and per-track merge state
  logic [POS_W-1:0]      mem_r   [MAX_TRACKS][EPT];
  logic [POS_W-1:0]      hv_r    [MAX_TRACKS];
  logic [CNT_W-1:0]      cnt_r   [MAX_TRACKS];
  logic [CNT_W-1:0]      cnt_nxt [MAX_TRACKS];
  logic [CNT_W-1:0]      head_r  [MAX_TRACKS];
  logic [CNT_W-1:0]      head_nxt[MAX_TRACKS];
  logic [MAX_TRACKS-1:0] inside_r, inside_nxt;
  logic [NEST_W-1:0]     nest_r, nest_nxt;
  logic                  drop_r, drop_nxt;
  bst_t                  state_r, state_nxt;

  // pending result, held until the next one shows whether it is last
  logic                  pend_v_r;
  logic [POS_W-1:0]      pend_pos_r;
  logic                  pend_beg_r;

  // output register
  logic                  out_v_r;
  logic [POS_W-1:0]      out_pos_r;
  logic                  out_beg_r;
  logic                  out_ovf_r;
  logic                  out_last_r;

  logic                  do_load, trk_full;
  logic                  found, cur_in;
  logic [TSEL_W-1:0]     best;
  logic [POS_W-1:0]      best_pos;
  logic                  emit_beg, emit_end, emit;
  logic                  can_load, step_go, fin, out_load;

  assign can_load = !out_v_r || out_chan.ready;

  // pop commands only while not merging
  assign pop     = (state_r == ST_IDLE) && !q_stat.empty;
  assign do_load = pop && (pop_item.cmd == CMD_LOAD);

  // full check of the addressed track
  always_comb begin
    trk_full = 1'b0;
    for (int t = 0; t < MAX_TRACKS; t++) begin
      if (pop_item.track == TRK_W'(t) && cnt_r[t] == CNT_W'(EPT)) begin
        trk_full = 1'b1;
      end
    end
  end

  // smallest head over the active tracks, ties to the lower track
  always_comb begin
    found    = 1'b0;
    best     = '0;
    best_pos = '0;
    cur_in   = 1'b0;
    for (int t = 0; t < MAX_TRACKS; t++) begin
      if (ACT_W'(t) < act_eff && head_r[t] < cnt_r[t]) begin
        if (!found || hv_r[t] < best_pos) begin
          found    = 1'b1;
          best     = TSEL_W'(t);
          best_pos = hv_r[t];
          cur_in   = inside_r[t];
        end
      end
    end
  end

  // union edge detection on the nesting level
  assign emit_beg = !cur_in && (nest_r == '0);
  assign emit_end = cur_in && (nest_r == NEST_W'(1));
  assign emit     = emit_beg || emit_end;

  // a step stalls only when it must push the pending result into a full output
  assign step_go  = (state_r == ST_MERGE) && found && (!emit || !pend_v_r || can_load);
  assign fin      = (state_r == ST_MERGE) && !found && (!pend_v_r || can_load);
  assign out_load = pend_v_r && ((step_go && emit) || fin);

  // next state of the per-read bookkeeping
  always_comb begin
    state_nxt  = state_r;
    inside_nxt = inside_r;
    nest_nxt   = nest_r;
    drop_nxt   = drop_r;
    for (int t = 0; t < MAX_TRACKS; t++) begin
      cnt_nxt[t]  = cnt_r[t];
      head_nxt[t] = head_r[t];
    end
    case (state_r)
      ST_IDLE: begin
        if (pop && pop_item.cmd == CMD_END) begin
          state_nxt = ST_MERGE;
        end
        if (do_load) begin
          if (trk_full) begin
            drop_nxt = 1'b1;
          end else begin
            for (int t = 0; t < MAX_TRACKS; t++) begin
              if (pop_item.track == TRK_W'(t)) begin
                cnt_nxt[t] = cnt_r[t] + 1'b1;
              end
            end
          end
        end
      end
      ST_MERGE: begin
        if (step_go) begin
          for (int t = 0; t < MAX_TRACKS; t++) begin
            if (best == TSEL_W'(t)) begin
              head_nxt[t]   = head_r[t] + 1'b1;
              inside_nxt[t] = !inside_r[t];
            end
          end
          if (!cur_in) begin
            nest_nxt = nest_r + 1'b1;
          end else if (nest_r != '0) begin
            nest_nxt = nest_r - 1'b1;
          end
        end else if (fin) begin
          state_nxt  = ST_IDLE;
          inside_nxt = '0;
          nest_nxt   = '0;
          drop_nxt   = 1'b0;
          for (int t = 0; t < MAX_TRACKS; t++) begin
            cnt_nxt[t]  = '0;
            head_nxt[t] = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      inside_r <= '0;
      nest_r   <= '0;
      drop_r   <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      for (int t = 0; t < MAX_TRACKS; t++) begin
        cnt_r[t]  <= '0;
        head_r[t] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      inside_r <= inside_nxt;
      nest_r   <= nest_nxt;
      drop_r   <= drop_nxt;
      for (int t = 0; t < MAX_TRACKS; t++) begin
        cnt_r[t]  <= cnt_nxt[t];
        head_r[t] <= head_nxt[t];
      end
      if (step_go && emit) begin
        pend_v_r <= 1'b1;
      end else if (fin) begin
        pend_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // store write and registered head reads
  always_ff @(posedge clk) begin
    for (int t = 0; t < MAX_TRACKS; t++) begin
      if (do_load && !trk_full && pop_item.track == TRK_W'(t)) begin
        mem_r[t][cnt_r[t][IDX_W-1:0]] <= pop_item.position;
      end
      hv_r[t] <= mem_r[t][head_nxt[t][IDX_W-1:0]];
    end
  end

  // pending and output payload
  always_ff @(posedge clk) begin
    if (step_go && emit) begin
      pend_pos_r <= best_pos;
      pend_beg_r <= emit_beg;
    end
    if (out_load) begin
      out_pos_r  <= pend_pos_r;
      out_beg_r  <= pend_beg_r;
      out_ovf_r  <= drop_r;
      out_last_r <= fin;
    end
  end

  assign out_chan.valid    = out_v_r;
  assign out_chan.edge_res = out_pos_r;
  assign out_chan.is_begin = out_beg_r;
  assign out_chan.overflow = out_ovf_r;
  assign out_chan.last     = out_last_r;

endmodule

`default_nettype wire

// File: hdl/kway_interval_union_merge.sv
// top level of the k-way interval union merge with its register port
//
// channel   | dir | handshake            | payload
// ----------+-----+----------------------+-------------------------------------
// in_chan   | in  | valid/ready          | cmd, track, position
// out_chan  | out | valid/ready          | edge_res, is_begin, overflow, last
// cfg (APB) | in  | psel/penable/pready  | paddr, pwdata, prdata (active_tracks)
//
// a load item is written into its track in the back end through the single store write port;
// an end-of-read item leaves the queue and starts the merge loop, which pops one head per
// cycle unless an output stall holds it, and closes the read once every stored endpoint is taken.
// a 4-entry command queue lets loads be accepted while a merge runs.
// output stalls hold the merge only when a new union edge must be pushed out.
// synchronous reset clears counts, levels and queues; the store needs no clearing.
`default_nettype none

module kway_interval_union_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  kium_in_if.sink                      in_chan,
  kium_out_if.source                   out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kium_pkg::ADDR_W-1:0]  paddr,
  input  logic [kium_pkg::DATA_W-1:0]  pwdata,
  output logic [kium_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import kium_pkg::*;

  logic [ACT_W-1:0] active_r;
  logic [ACT_W-1:0] act_eff;
  logic             push, pop;
  q_item_t          push_item, pop_item;
  q_stat_t          q_stat;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RIDX_ACTIVE) ? DATA_W'(active_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == RIDX_ACTIVE) begin
      active_r <= pwdata[ACT_W-1:0];
    end
  end

  assign act_eff = eff_tracks(active_r);

  // front, queue and back
  kium_front u_front (
    .in_chan   (in_chan),
    .act_eff   (act_eff),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  kium_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  kium_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .act_eff  (act_eff),
    .pop_item (pop_item),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

// File: hdl/kium_check.sv
// port-level checks for the interval union merge and their binding
`default_nettype none

module kium_check (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [kium_pkg::POS_W-1:0]  out_edge_res,
  input logic                        out_is_begin,
  input logic                        out_overflow,
  input logic                        out_last,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [kium_pkg::ADDR_W-1:0] paddr,
  input logic [kium_pkg::DATA_W-1:0] pwdata,
  input logic [kium_pkg::DATA_W-1:0] prdata
);
  import kium_pkg::*;

  logic exp_beg_r;

  // union edges alternate, and every read opens with a begin
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_beg_r <= 1'b1;
    end else if (out_valid && out_ready) begin
      exp_beg_r <= out_last ? 1'b1 : !out_is_begin;
    end
  end

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_edge_res) &&
    $stable(out_is_begin) && $stable(out_overflow) && $stable(out_last))
    else $error("stalled result changed");

  // begin and end alternate within a read
  a_edge_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> out_is_begin == exp_beg_r)
    else $error("union edges out of order");

  // written track count reads back
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && paddr[2] == RIDX_ACTIVE |=>
    (paddr[2] != RIDX_ACTIVE) || (prdata == DATA_W'($past(pwdata[ACT_W-1:0]))))
    else $error("track count register readback mismatch");

endmodule

bind kway_interval_union_merge kium_check u_kium_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_edge_res (out_chan.edge_res),
  .out_is_begin (out_chan.is_begin),
  .out_overflow (out_chan.overflow),
  .out_last     (out_chan.last),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata)
);

`default_nettype wire

// File: test/tb_kway_interval_union_merge.sv
// testbench for kway_interval_union_merge: queued stimulus, clocked driver and monitor, predictor
`timescale 1ns / 100ps

module tb_kway_interval_union_merge;
  import kium_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_EDGES = 64;
  localparam int RANDOM_TARGET = 144;
  localparam int PHASES = 6;

  // kinds of planned reads
  localparam int RD_CLEAN    = 0;
  localparam int RD_ODD      = 1;
  localparam int RD_SHUFFLED = 2;
  localparam int RD_OVERFLOW = 3;
  localparam int RD_STRAY    = 4;
  localparam int RD_EMPTY    = 5;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             is_begin;
    logic             overflow;
    logic             last;
  } union_edge_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  kium_in_if  in_bus ();
  kium_out_if out_bus ();

  kway_interval_union_merge u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus and expectation stores
  q_item_t     pending_q[$];
  union_edge_t edges_q[$];

  // predictor state
  logic [POS_W-1:0] track_mem [MAX_TRACKS][EPT];
  int               track_fill [MAX_TRACKS];
  logic             track_inside [MAX_TRACKS];
  int               nest_cnt;
  logic             drop_seen;
  logic [ACT_W-1:0] tracks_reg;

  // run bookkeeping
  int   cycle_cnt;
  int   err_cnt;
  int   acc_cnt;
  int   chk_cnt;
  int   read_cnt;
  int   ovf_reads;
  int   planned;
  bit   calm;
  bit   in_taken;
  int   in_gap;
  int   out_gap;

  function automatic int clamp_tracks(input logic [ACT_W-1:0] raw);
    int e;
    e = raw;
    if (e == 0) e = 1;
    if (e > MAX_TRACKS) e = MAX_TRACKS;
    return e;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_cnt, what, got, want);
  endtask

  // k-way merge of the stored tracks into union edges
  task automatic union_tracks(input int e);
    int               head [MAX_TRACKS];
    union_edge_t      read_q[$];
    union_edge_t      r;
    int               best;
    int               t;
    logic [POS_W-1:0] best_pos;
    for (t = 0; t < MAX_TRACKS; t++) head[t] = 0;
    best = 0;
    best_pos = '0;
    while (best >= 0) begin
      best = -1;
      for (t = 0; t < e; t++) begin
        if (head[t] < track_fill[t]) begin
          if (best < 0 || track_mem[t][head[t]] < best_pos) begin
            best = t;
            best_pos = track_mem[t][head[t]];
          end
        end
      end
      if (best >= 0) begin
        track_inside[best] = !track_inside[best];
        r.pos = best_pos;
        r.overflow = drop_seen;
        r.last = 1'b0;
        if (track_inside[best]) begin
          if (nest_cnt == 0 && read_q.size() < MAX_EDGES) begin
            r.is_begin = 1'b1;
            read_q.push_back(r);
          end
          nest_cnt++;
        end else if (nest_cnt > 0) begin
          nest_cnt--;
          if (nest_cnt == 0 && read_q.size() < MAX_EDGES) begin
            r.is_begin = 1'b0;
            read_q.push_back(r);
          end
        end
        head[best]++;
      end
    end
    if (read_q.size() > 0) begin
      r = read_q.pop_back();
      r.last = 1'b1;
      read_q.push_back(r);
    end
    if (drop_seen) ovf_reads++;
    foreach (read_q[i]) edges_q.push_back(read_q[i]);
    read_cnt++;
    // per-read state cleared after every merge
    for (t = 0; t < MAX_TRACKS; t++) begin
      track_fill[t] = 0;
      track_inside[t] = 1'b0;
    end
    nest_cnt = 0;
    drop_seen = 1'b0;
  endtask

  task automatic absorb_item(input q_item_t it);
    int e;
    int t;
    e = clamp_tracks(tracks_reg);
    t = it.track;
    if (it.cmd == CMD_LOAD) begin
      if (t < e) begin
        if (track_fill[t] >= EPT) begin
          drop_seen = 1'b1;
        end else begin
          track_mem[t][track_fill[t]] = it.position;
          track_fill[t]++;
        end
      end
    end else begin
      union_tracks(e);
    end
  endtask

  task automatic check_edge(input union_edge_t got);
    union_edge_t want;
    if (edges_q.size() == 0) begin
      report_mismatch("result with nothing pending", 32'(got.pos), 0);
      return;
    end
    want = edges_q.pop_front();
    chk_cnt++;
    if (got.pos != want.pos) report_mismatch("edge_res", 32'(got.pos), 32'(want.pos));
    if (got.is_begin != want.is_begin)
      report_mismatch("is_begin", 32'(got.is_begin), 32'(want.is_begin));
    if (got.overflow != want.overflow)
      report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
    if (got.last != want.last) report_mismatch("last", 32'(got.last), 32'(want.last));
  endtask

  // monitor: result check first, then input acceptance into the predictor
  always @(posedge clk) begin
    union_edge_t got;
    q_item_t     it;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        got.pos = out_bus.edge_res;
        got.is_begin = out_bus.is_begin;
        got.overflow = out_bus.overflow;
        got.last = out_bus.last;
        check_edge(got);
      end
      if (in_bus.valid && in_bus.ready) begin
        it.cmd = in_bus.cmd;
        it.track = in_bus.track;
        it.position = in_bus.position;
        absorb_item(it);
        acc_cnt++;
        in_taken = 1'b1;
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_cnt,
               edges_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // input driver: holds an item until taken, idles only between items
  always @(negedge clk) begin
    logic    nxt_valid;
    q_item_t nxt;
    nxt_valid = in_bus.valid;
    nxt.cmd = in_bus.cmd;
    nxt.track = in_bus.track;
    nxt.position = in_bus.position;
    if (in_taken) begin
      in_taken = 1'b0;
      void'(pending_q.pop_front());
      nxt_valid = 1'b0;
    end
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (!nxt_valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 18);
      end else if (pending_q.size() > 0) begin
        nxt = pending_q[0];
        nxt_valid = 1'b1;
      end
    end
    in_bus.valid <= nxt_valid;
    in_bus.cmd <= nxt.cmd;
    in_bus.track <= nxt.track;
    in_bus.position <= nxt.position;
  end

  // result side back-pressure
  always @(negedge clk) begin
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (out_gap > 0) begin
      out_gap--;
      nxt_ready = 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 18);
      nxt_ready = 1'b0;
    end
    out_bus.ready <= nxt_ready;
  end

  task automatic queue_item(input logic cmd, input int trk, input logic [POS_W-1:0] pos);
    q_item_t it;
    it.cmd = cmd;
    it.track = TRK_W'(trk);
    it.position = pos;
    pending_q.push_back(it);
  endtask

  // build one read: per-track endpoint lists, interleaved, then end of read
  task automatic plan_read(input int kind, input int e);
    q_item_t     flat[$];
    q_item_t     it;
    int          lo [MAX_TRACKS];
    int          hi [MAX_TRACKS];
    int          cur [MAX_TRACKS];
    int          n;
    int          t;
    int          k;
    int          left;
    int          pick;
    int          ov_trk;
    bit          narrow;
    logic [31:0] p;
    narrow = ($urandom_range(0, 1) == 0);
    ov_trk = $urandom_range(0, e - 1);
    for (t = 0; t < MAX_TRACKS; t++) begin
      lo[t] = flat.size();
      n = 0;
      if (t >= e) begin
        if (kind == RD_STRAY) n = $urandom_range(1, 3);
      end else begin
        case (kind)
          RD_ODD:      n = 2 * $urandom_range(0, 3) + $urandom_range(0, 1);
          RD_SHUFFLED: n = $urandom_range(0, 6);
          RD_OVERFLOW: n = (t == ov_trk) ? $urandom_range(EPT + 1, EPT + 4)
                                         : 2 * $urandom_range(0, 2);
          RD_EMPTY:    n = 0;
          default: begin
            n = 2 * $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0) n = 2 * $urandom_range(4, EPT / 2);
          end
        endcase
        planned += n;
      end
      if (narrow) p = $urandom_range(0, 40);
      else p = $urandom_range(0, 32'h7FFF_FFFF);
      for (k = 0; k < n; k++) begin
        if (t >= e) begin
          p = $urandom_range(0, 32'h7FFF_FFFF);
        end else if (kind == RD_SHUFFLED) begin
          p = narrow ? $urandom_range(0, 60) : $urandom_range(0, 32'h7FFF_FFFF);
        end else if (k > 0) begin
          p = p + (narrow ? $urandom_range(0, 12) : $urandom_range(0, 32'h0400_0000));
          if (p > 32'h7FFF_FFFF) p = 32'h7FFF_FFFF;
        end
        it.cmd = CMD_LOAD;
        it.track = TRK_W'(t);
        it.position = p[POS_W-1:0];
        flat.push_back(it);
      end
      hi[t] = flat.size();
      cur[t] = lo[t];
    end
    left = flat.size();
    while (left > 0) begin
      pick = $urandom_range(0, MAX_TRACKS - 1);
      if (cur[pick] < hi[pick]) begin
        pending_q.push_back(flat[cur[pick]]);
        cur[pick]++;
        left--;
      end
    end
    // track and position carry noise on the end item
    queue_item(CMD_END, $urandom_range(0, 3), POS_W'($urandom));
    planned++;
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == {RIDX_ACTIVE, 2'b00}) tracks_reg = val[ACT_W-1:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // wait for drained queues, then let any merge with no results finish
  task automatic wait_idle();
    do @(posedge clk); while (pending_q.size() != 0 || in_bus.valid || edges_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // main sequence
  initial begin
    logic [ACT_W-1:0] settings [PHASES];
    int               ph;
    int               goal;
    int               kind;
    int               e;
    settings[0] = 3'd1;
    settings[1] = 3'd0;
    settings[2] = 3'd7;
    settings[3] = 3'd2;
    settings[4] = 3'd3;
    settings[5] = 3'd4;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.cmd = CMD_LOAD;
    in_bus.track = '0;
    in_bus.position = '0;
    out_bus.ready = 1'b0;
    cycle_cnt = 0;
    err_cnt = 0;
    acc_cnt = 0;
    chk_cnt = 0;
    read_cnt = 0;
    ovf_reads = 0;
    planned = 0;
    calm = 1'b0;
    in_taken = 1'b0;
    in_gap = 0;
    out_gap = 0;
    tracks_reg = ACTIVE_RST;
    nest_cnt = 0;
    drop_seen = 1'b0;
    for (int t = 0; t < MAX_TRACKS; t++) begin
      track_fill[t] = 0;
      track_inside[t] = 1'b0;
    end
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty read, extreme coordinates, ties and overlaps, odd and unordered tracks
    queue_item(CMD_END, 3, 31'h7FFF_FFFF);
    queue_item(CMD_LOAD, 0, 31'h0);
    queue_item(CMD_LOAD, 0, 31'h7FFF_FFFF);
    queue_item(CMD_END, 0, 31'h0);
    queue_item(CMD_LOAD, 0, 31'd10);
    queue_item(CMD_LOAD, 1, 31'd10);
    queue_item(CMD_LOAD, 2, 31'd25);
    queue_item(CMD_LOAD, 0, 31'd20);
    queue_item(CMD_LOAD, 3, 31'd50);
    queue_item(CMD_LOAD, 1, 31'd30);
    queue_item(CMD_LOAD, 2, 31'd40);
    queue_item(CMD_LOAD, 3, 31'd60);
    queue_item(CMD_END, 2, 31'h5555_5555);
    queue_item(CMD_LOAD, 1, 31'd5);
    queue_item(CMD_END, 1, 31'h2AAA_AAAA);
    queue_item(CMD_LOAD, 2, 31'd100);
    queue_item(CMD_LOAD, 3, 31'd70);
    queue_item(CMD_LOAD, 2, 31'd50);
    queue_item(CMD_LOAD, 3, 31'd80);
    queue_item(CMD_END, 0, 31'h0);
    wait_idle();

    // random reads across track-count settings, quiet handshakes in the last one
    for (ph = 0; ph < PHASES; ph++) begin
      write_reg({RIDX_ACTIVE, 2'b00}, DATA_W'(settings[ph]));
      e = clamp_tracks(settings[ph]);
      if (ph == PHASES - 1) calm = 1'b1;
      goal = planned + RANDOM_TARGET / PHASES;
      while (planned < goal) begin
        kind = $urandom_range(0, 19);
        if (kind <= 10 || kind == 19) kind = RD_CLEAN;
        else if (kind <= 12) kind = RD_ODD;
        else if (kind <= 14) kind = RD_SHUFFLED;
        else if (kind == 15) kind = RD_OVERFLOW;
        else if (kind <= 17) kind = (e < MAX_TRACKS) ? RD_STRAY : RD_CLEAN;
        else kind = RD_EMPTY;
        plan_read(kind, e);
      end
      wait_idle();
    end

    $display("covered %0d accepted items in %0d reads (%0d with dropped endpoints),",
             acc_cnt, read_cnt, ovf_reads);
    $display("checked %0d union edges over %0d track-count settings", chk_cnt, PHASES + 1);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
